@@ src/i2c_sensor_command_sequencer_defines.svh @@
// Assertion macros for the I2C sensor command sequencer.
// Expects clk and rst_n in the scope that uses them; no other dependencies.
`ifndef I2C_SENSOR_COMMAND_SEQUENCER_DEFINES_SVH
`define I2C_SENSOR_COMMAND_SEQUENCER_DEFINES_SVH

// Property must hold at every edge out of reset.
`define I2CSEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen out of reset.
`define I2CSEQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/i2cseq_pkg.sv @@
// Shared types, codes and the step-program decode for the sequencer.
// No dependencies; imported by the front end, the executor and the top level.
package i2cseq_pkg;

  // Defaults for top-level parameters
  localparam int PENDING_DEPTH_DEF = 4;
  localparam int WAIT_WIDTH_DEF    = 16;
  // Depth of the event queue and of the result queue
  localparam int QUEUE_DEPTH       = 2;
  localparam int CFG_WAIT_W        = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_INDEX_W       = 3;

  // Input action codes
  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_BUS  = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_XFER      = 2'd0;
  localparam logic [1:0] KIND_INIT_DONE = 2'd1;
  localparam logic [1:0] KIND_READ_DONE = 2'd2;
  localparam logic [1:0] KIND_ABORT     = 2'd3;

  // Program select
  localparam logic PROG_INIT = 1'b0;
  localparam logic PROG_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEV_ADDR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EN_SEL   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PWR_ON   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PWR_RUN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_SEL  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_SEL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PWR_WAIT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_INT_WAIT = 3'd7;

  localparam logic [CFG_WAIT_W-1:0] PWR_WAIT_RST = 16'd4;
  localparam logic [CFG_WAIT_W-1:0] INT_WAIT_RST = 16'd701;

  typedef struct packed {
    logic [6:0]            dev_addr;
    logic [7:0]            en_sel;
    logic [7:0]            pwr_on;
    logic [7:0]            pwr_run;
    logic [7:0]            low_sel;
    logic [7:0]            high_sel;
    logic [CFG_WAIT_W-1:0] pwr_wait;
    logic [CFG_WAIT_W-1:0] int_wait;
  } cfg_t;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_BUS   = 2'd1,
    EV_TICK  = 2'd2
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic       prog;
    logic       err;
    logic [7:0] rbyte;
  } ev_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        rd;
    logic        start;
    logic        stop;
    logic [6:0]  addr;
    logic [7:0]  wbyte;
    logic [15:0] clear;
  } res_t;

  // Status from the executor, for checks at the top level
  typedef struct packed {
    logic fire;
    logic idle;
    logic start;
    logic emit;
  } stat_t;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_XFER = 2'd1,
    RUN_WAIT = 2'd2,
    RUN_DONE = 2'd3
  } run_act_t;

  typedef enum logic [2:0] {
    SRC_NONE     = 3'd0,
    SRC_EN_SEL   = 3'd1,
    SRC_PWR_ON   = 3'd2,
    SRC_PWR_RUN  = 3'd3,
    SRC_LOW_SEL  = 3'd4,
    SRC_HIGH_SEL = 3'd5
  } src_t;

  typedef struct packed {
    run_act_t   act;
    logic [2:0] step;   // step the program rests on
    logic       rd;
    logic       start;
    logic       stop;
    src_t       src;
    logic       w_int;  // wait uses the integration time
  } run_t;

  // Resolve the steps from s onward up to the first one that issues a
  // transfer, starts a wait or ends the program. Skipped steps fold in here.
  function automatic run_t run_from(input logic prog, input logic [2:0] s,
                                    input logic pwr_zero, input logic int_zero);
    run_t r;
    r = '0;
    r.step = s;
    if (prog == PROG_INIT) begin
      case (s)
        3'd0, 3'd3: begin
          r.act = RUN_XFER; r.start = 1'b1; r.src = SRC_EN_SEL;
        end
        3'd1: begin
          r.act = RUN_XFER; r.stop = 1'b1; r.src = SRC_PWR_ON;
        end
        3'd2: begin
          if (pwr_zero) begin
            r.act = RUN_XFER; r.start = 1'b1; r.src = SRC_EN_SEL; r.step = 3'd3;
          end else begin
            r.act = RUN_WAIT;
          end
        end
        3'd4: begin
          r.act = RUN_XFER; r.stop = 1'b1; r.src = SRC_PWR_RUN;
        end
        3'd5: begin
          if (int_zero) begin
            r.act = RUN_DONE; r.step = 3'd6;
          end else begin
            r.act = RUN_WAIT; r.w_int = 1'b1;
          end
        end
        3'd6: begin
          r.act = RUN_DONE;
        end
        default: begin
          r.act = RUN_NONE;
        end
      endcase
    end else begin
      case (s)
        3'd0: begin
          r.act = RUN_XFER; r.start = 1'b1; r.src = SRC_LOW_SEL;
        end
        3'd1, 3'd4: begin
          r.act = RUN_XFER; r.rd = 1'b1; r.start = 1'b1; r.stop = 1'b1;
        end
        3'd2, 3'd3: begin
          r.act = RUN_XFER; r.start = 1'b1; r.src = SRC_HIGH_SEL; r.step = 3'd3;
        end
        default: begin
          r.act = RUN_DONE; r.step = 3'd7;
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/i2cseq_fifo.sv @@
// Small register FIFO, first-word fall-through, used for events and results.
// Depends on nothing but its parameters.
module i2cseq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop_ok) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ src/i2cseq_front.sv @@
// Front end: classifies input beats into events and queues them.
// Depends on i2cseq_pkg and i2cseq_fifo.
module i2cseq_front
  import i2cseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_action,
  input  logic       in_bus_error,
  input  logic [7:0] in_read_byte,
  output logic       ev_valid,
  output ev_t        ev,
  input  logic       ev_pop
);

  ev_t  ev_in;
  logic ev_empty;
  logic [$bits(ev_t)-1:0] ev_rdata;

  // Keep bus status only on bus completions; zero it otherwise.
  always_comb begin
    ev_in = '0;
    case (in_action)
      ACT_INIT: begin
        ev_in.kind = EV_START;
        ev_in.prog = PROG_INIT;
      end
      ACT_READ: begin
        ev_in.kind = EV_START;
        ev_in.prog = PROG_READ;
      end
      ACT_BUS: begin
        ev_in.kind  = EV_BUS;
        ev_in.err   = in_bus_error;
        ev_in.rbyte = in_read_byte;
      end
      default: begin
        ev_in.kind = EV_TICK;
      end
    endcase
  end

  i2cseq_fifo #(
    .WIDTH ($bits(ev_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ev_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (ev_in),
    .full  (full),
    .pop   (ev_pop),
    .rdata (ev_rdata),
    .empty (ev_empty)
  );

  assign ev_valid = !ev_empty;
  assign ev       = ev_t'(ev_rdata);

endmodule

@@ src/i2cseq_exec.sv @@
// Back end: program sequencer, wait counter and pending start queue.
// Depends on i2cseq_pkg; takes events from the front, writes results out.
module i2cseq_exec
  import i2cseq_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int WAIT_WIDTH    = WAIT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  ev_valid,
  input  ev_t   ev,
  output logic  ev_pop,
  input  logic  res_full,
  output logic  res_push,
  output res_t  res,
  output stat_t stat
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int TW = (WAIT_WIDTH > CFG_WAIT_W) ? WAIT_WIDTH : CFG_WAIT_W;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_BUS  = 3'b010,
    PH_TIME = 3'b100
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  prog_r, prog_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [WAIT_WIDTH-1:0] wait_r, wait_nxt, wait_dec;
  logic [7:0]            low_r, low_nxt;
  logic [7:0]            high_r, high_nxt;
  logic                  pend_r [PENDING_DEPTH];
  logic                  pend_nxt [PENDING_DEPTH];
  logic [CW-1:0]         pcnt_r, pcnt_nxt, widx;

  logic       fire, do_run, push_req, pop_req, push_ok, abort, pend_full;
  logic       run_prog;
  logic [2:0] run_step;
  run_t       run;

  function automatic logic [WAIT_WIDTH-1:0] sat_wait(input logic [CFG_WAIT_W-1:0] t);
    logic [TW-1:0] ext;
    ext = TW'(t);
    if (ext > TW'({WAIT_WIDTH{1'b1}})) begin
      return '1;
    end
    return ext[WAIT_WIDTH-1:0];
  endfunction

  // Take an event only when its result, if any, has a slot.
  assign fire      = ev_valid && !res_full;
  assign ev_pop    = fire;
  assign pend_full = (pcnt_r == CW'(PENDING_DEPTH));
  assign wait_dec  = (wait_r != '0) ? wait_r - WAIT_WIDTH'(1) : wait_r;

  // Event decode
  always_comb begin
    do_run   = 1'b0;
    push_req = 1'b0;
    pop_req  = 1'b0;
    abort    = 1'b0;
    run_prog = prog_r;
    run_step = step_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    wait_nxt = wait_r;
    if (fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (ev.kind == EV_START && pcnt_r == '0) begin
            do_run   = 1'b1;
            run_prog = ev.prog;
            run_step = 3'd0;
          end else if (pcnt_r != '0) begin
            // Queue the new start behind the others, serve the oldest.
            push_req = (ev.kind == EV_START);
            pop_req  = 1'b1;
            do_run   = 1'b1;
            run_prog = pend_r[0];
            run_step = 3'd0;
          end
        end
        PH_BUS: begin
          if (ev.kind == EV_START) begin
            push_req = 1'b1;
          end else if (ev.kind == EV_BUS) begin
            if (ev.err) begin
              abort = 1'b1;
            end else begin
              if (prog_r == PROG_READ && step_r == 3'd1) begin
                low_nxt = ev.rbyte;
              end
              if (prog_r == PROG_READ && step_r == 3'd4) begin
                high_nxt = ev.rbyte;
              end
              do_run   = 1'b1;
              run_step = step_r + 3'd1;
            end
          end
        end
        PH_TIME: begin
          if (ev.kind == EV_START) begin
            push_req = 1'b1;
          end else if (ev.kind == EV_TICK) begin
            if (wait_dec != '0) begin
              wait_nxt = wait_dec;
            end else begin
              wait_nxt = wait_dec;
              do_run   = 1'b1;
              run_step = step_r + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign run = run_from(run_prog, run_step, cfg.pwr_wait == '0, cfg.int_wait == '0);

  // Program step outcome and result
  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    step_nxt  = step_r;
    res_push  = 1'b0;
    res       = '0;
    if (phase_r != PH_IDLE && phase_r != PH_BUS && phase_r != PH_TIME) begin
      phase_nxt = PH_IDLE;
    end
    if (abort) begin
      phase_nxt = PH_IDLE;
      res_push  = 1'b1;
      res.kind  = KIND_ABORT;
    end else if (do_run) begin
      prog_nxt = run_prog;
      step_nxt = run.step;
      case (run.act)
        RUN_XFER: begin
          phase_nxt = PH_BUS;
          res_push  = 1'b1;
          res.kind  = KIND_XFER;
          res.rd    = run.rd;
          res.start = run.start;
          res.stop  = run.stop;
          res.addr  = cfg.dev_addr;
          case (run.src)
            SRC_EN_SEL:   res.wbyte = cfg.en_sel;
            SRC_PWR_ON:   res.wbyte = cfg.pwr_on;
            SRC_PWR_RUN:  res.wbyte = cfg.pwr_run;
            SRC_LOW_SEL:  res.wbyte = cfg.low_sel;
            SRC_HIGH_SEL: res.wbyte = cfg.high_sel;
            default:      res.wbyte = 8'd0;
          endcase
        end
        RUN_WAIT: begin
          phase_nxt = PH_TIME;
        end
        RUN_DONE: begin
          phase_nxt = PH_IDLE;
          res_push  = 1'b1;
          if (run_prog == PROG_READ) begin
            res.kind  = KIND_READ_DONE;
            res.clear = {high_nxt, low_nxt};
          end else begin
            res.kind  = KIND_INIT_DONE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Pending start queue: pop shifts toward entry zero, push lands at the tail.
  assign push_ok = push_req && !pend_full;
  assign widx    = pop_req ? pcnt_r - CW'(1) : pcnt_r;

  always_comb begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      pend_nxt[i] = pend_r[i];
    end
    if (pop_req) begin
      for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
        pend_nxt[i] = pend_r[i + 1];
      end
    end
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (push_ok && widx == CW'(i)) begin
        pend_nxt[i] = ev.prog;
      end
    end
    pcnt_nxt = pcnt_r;
    if (push_ok && !pop_req) begin
      pcnt_nxt = pcnt_r + CW'(1);
    end else if (!push_ok && pop_req) begin
      pcnt_nxt = pcnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prog_r  <= PROG_INIT;
      step_r  <= '0;
      wait_r  <= '0;
      low_r   <= '0;
      high_r  <= '0;
      pcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      prog_r  <= prog_nxt;
      step_r  <= step_nxt;
      wait_r  <= (do_run && run.act == RUN_WAIT) ?
                 sat_wait(run.w_int ? cfg.int_wait : cfg.pwr_wait) : wait_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      pend_r[i] <= pend_nxt[i];
    end
  end

  assign stat.fire  = fire;
  assign stat.idle  = (phase_r == PH_IDLE);
  assign stat.start = (ev.kind == EV_START);
  assign stat.emit  = res_push;

endmodule

@@ src/i2c_sensor_command_sequencer.sv @@
// Top level of the I2C sensor command sequencer: configuration registers,
// front end, executor and result queue. Depends on i2cseq_pkg, i2cseq_fifo,
// i2cseq_front, i2cseq_exec and the assertion macro header.
//
//  Channel   Direction  Handshake          Beat contents
//  input     in         push / full        in_action, in_bus_error, in_read_byte
//  result    out        pop / empty        out_result_kind ... out_clear_value
//  config    in         cfg_we (no wait)   cfg_index, cfg_wdata
//
// One input beat is taken every cycle that full is low; the executor
// resolves one event per cycle while the result queue is not full, so
// the sustained rate is one beat a cycle while results are drained. A result
// reaches the out_ ports by way of the event queue, then the result queue.
// Reset (rst_n low at a clock edge) empties both queues, idles the
// sequencer and loads the register defaults; no clearing pass is needed.
// A full result queue holds events in the event queue, which then raises full.
`include "i2c_sensor_command_sequencer_defines.svh"

module i2c_sensor_command_sequencer
  import i2cseq_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int WAIT_WIDTH    = WAIT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             in_action,
  input  logic                   in_bus_error,
  input  logic [7:0]             in_read_byte,
  // result channel
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             out_result_kind,
  output logic                   out_bus_read,
  output logic                   out_bus_start,
  output logic                   out_bus_stop,
  output logic [6:0]             out_bus_address,
  output logic [7:0]             out_bus_write_byte,
  output logic [15:0]            out_clear_value,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r, cfg_nxt;
  logic  ev_valid, ev_pop;
  ev_t   ev;
  logic  res_push, res_full;
  res_t  res, res_q;
  stat_t stat;
  logic [$bits(res_t)-1:0] res_rdata;
  logic  idle_start, bus_fields_zero, stray_bus_fields, stray_clear;

  // Configuration writes: truncate the data to each register's width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEV_ADDR: cfg_nxt.dev_addr = cfg_wdata[6:0];
        REG_EN_SEL:   cfg_nxt.en_sel   = cfg_wdata[7:0];
        REG_PWR_ON:   cfg_nxt.pwr_on   = cfg_wdata[7:0];
        REG_PWR_RUN:  cfg_nxt.pwr_run  = cfg_wdata[7:0];
        REG_LOW_SEL:  cfg_nxt.low_sel  = cfg_wdata[7:0];
        REG_HIGH_SEL: cfg_nxt.high_sel = cfg_wdata[7:0];
        REG_PWR_WAIT: cfg_nxt.pwr_wait = cfg_wdata[CFG_WAIT_W-1:0];
        REG_INT_WAIT: cfg_nxt.int_wait = cfg_wdata[CFG_WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{7'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, PWR_WAIT_RST, INT_WAIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify and queue input beats.
  i2cseq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_action    (in_action),
    .in_bus_error (in_bus_error),
    .in_read_byte (in_read_byte),
    .ev_valid     (ev_valid),
    .ev           (ev),
    .ev_pop       (ev_pop)
  );

  // Back: run the step programs, one event per cycle while the result queue has room.
  i2cseq_exec #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .WAIT_WIDTH    (WAIT_WIDTH)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_pop   (ev_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res),
    .stat     (stat)
  );

  // Result queue: lets the executor keep going while the consumer stalls.
  i2cseq_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_q              = res_t'(res_rdata);
  assign out_result_kind    = res_q.kind;
  assign out_bus_read       = res_q.rd;
  assign out_bus_start      = res_q.start;
  assign out_bus_stop       = res_q.stop;
  assign out_bus_address    = res_q.addr;
  assign out_bus_write_byte = res_q.wbyte;
  assign out_clear_value    = res_q.clear;

  // Terms for the checks below
  assign idle_start       = stat.fire && stat.idle && stat.start;
  assign bus_fields_zero  = (out_bus_address == 7'd0) && (out_bus_write_byte == 8'd0) &&
                            !out_bus_start && !out_bus_stop && !out_bus_read;
  assign stray_bus_fields = !empty && (out_result_kind != KIND_XFER) && !bus_fields_zero;
  assign stray_clear      = !empty && (out_result_kind != KIND_READ_DONE) &&
                            (out_clear_value != 16'd0);

  // A start taken while idle always issues a first transfer: of the oldest queued start, else its own.
  `I2CSEQ_ASSERT(a_idle_start_emits, idle_start |-> stat.emit, "idle start gave no result")
  // Only transfers carry bus fields.
  `I2CSEQ_NEVER(a_nonxfer_clean, stray_bus_fields, "bus fields set on a non-transfer result")
  // The joined reading appears on read done only.
  `I2CSEQ_NEVER(a_clear_only_done, stray_clear, "reading set outside read done")
  // The executor never retires an event into a full result queue.
  `I2CSEQ_NEVER(a_fire_into_full, stat.fire && res_full, "event taken while result queue full")

endmodule
